// ===== src/hts_pkg.sv =====
`default_nettype none
package hts_pkg;

  localparam int QDepthDef = 4;

  localparam logic [20:0] SylBase   = 21'h0AC00;
  localparam logic [20:0] SylLast   = 21'h0D7A3;
  localparam logic [20:0] LeadBase  = 21'h01100;
  localparam logic [20:0] LeadLast  = 21'h01112;
  localparam logic [20:0] VowelBase = 21'h01161;
  localparam logic [20:0] VowelLast = 21'h01175;
  localparam logic [20:0] TrailBase = 21'h011A8;
  localparam logic [20:0] TrailLast = 21'h011C2;
  localparam logic [4:0]  SilentInit = 5'd11;
  localparam logic [15:0] SpaceCh   = 16'h0020;
  localparam int          RowLen    = 588;
  localparam int          ColLen    = 28;

  typedef struct packed {
    logic [20:0] codepoint;
    logic        end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [15:0] phoneme;
    logic        end_marker;
  } out_item_t;

  typedef enum logic [2:0] {
    CL_WS, CL_PUNCT, CL_SYL, CL_LETTER, CL_LEAD, CL_VOWEL, CL_TRAIL, CL_OTHER
  } cls_e;

  typedef enum logic [1:0] {
    PH_IDLE, PH_LEAD, PH_VOWEL
  } phase_e;

  typedef enum logic [3:0] {
    B_S1_INI, B_S1_MED0, B_S1_MED1, B_S1_FIN, B_SPACE, B_CHAR,
    B_S2_INI, B_S2_MED0, B_S2_MED1, B_S2_FIN, B_END
  } beat_e;

  localparam int NumBeats = 11;

  typedef struct packed {
    cls_e        cls;
    logic [4:0]  idx;
    logic [9:0]  rem;
    logic [15:0] ch;
    logic        eot;
  } cls_item_t;

  typedef struct packed {
    logic       v;
    logic [4:0] ini;
    logic [4:0] med;
    logic [4:0] fin;
  } syl_t;

  typedef struct packed {
    syl_t        s1;
    logic        sp;
    logic        cv;
    logic [15:0] ch;
    syl_t        s2;
    logic        endm;
  } rec_t;

  typedef struct packed {
    phase_e     phase;
    logic [4:0] pl;
    logic [4:0] pv;
    logic       hv;
    logic [4:0] hi;
    logic [4:0] hm;
    logic [4:0] hf;
    logic       sw;
    logic       tn;
  } st_t;

  typedef struct packed {
    st_t  st;
    rec_t rec;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [15:0] initial_ph(input logic [4:0] i);
    logic [15:0] r;
    case (i)
      5'd0:  r = 16'h006B;
      5'd1:  r = 16'hE04D;
      5'd2:  r = 16'h006E;
      5'd3:  r = 16'h0074;
      5'd4:  r = 16'hE04C;
      5'd5:  r = 16'h027E;
      5'd6:  r = 16'h006D;
      5'd7:  r = 16'h0070;
      5'd8:  r = 16'hE04B;
      5'd9:  r = 16'h0073;
      5'd10: r = 16'hE04E;
      5'd12: r = 16'hE023;
      5'd13: r = 16'hE04F;
      5'd14: r = 16'hE024;
      5'd15: r = 16'hE022;
      5'd16: r = 16'hE021;
      5'd17: r = 16'hE020;
      5'd18: r = 16'h0068;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] medial_ph0(input logic [4:0] m);
    logic [15:0] r;
    case (m)
      5'd0, 5'd2, 5'd3, 5'd6, 5'd7, 5'd12, 5'd17: r = (m == 5'd0) ? 16'h0061 : 16'h006A;
      5'd1:  r = 16'h025B;
      5'd4:  r = 16'h028C;
      5'd5:  r = 16'h0065;
      5'd8:  r = 16'h006F;
      5'd9, 5'd10, 5'd11, 5'd14, 5'd15, 5'd16: r = 16'h0077;
      5'd13: r = 16'h0075;
      5'd18: r = 16'h026F;
      5'd19: r = 16'h0270;
      5'd20: r = 16'h0069;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] medial_ph1(input logic [4:0] m);
    logic [15:0] r;
    case (m)
      5'd2, 5'd9:   r = 16'h0061;
      5'd3, 5'd10:  r = 16'h025B;
      5'd6, 5'd14:  r = 16'h028C;
      5'd7, 5'd11, 5'd15: r = 16'h0065;
      5'd12: r = 16'h006F;
      5'd16, 5'd19: r = 16'h0069;
      5'd17: r = 16'h0075;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] final_ph(input logic [4:0] f);
    logic [15:0] r;
    case (f)
      5'd1, 5'd2, 5'd3, 5'd9, 5'd24: r = 16'hE050;
      5'd4, 5'd5, 5'd6:              r = 16'h006E;
      5'd7, 5'd19, 5'd20, 5'd22, 5'd23, 5'd25, 5'd27: r = 16'hE051;
      5'd8, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15: r = 16'h006C;
      5'd10, 5'd16:                  r = 16'h006D;
      5'd17, 5'd18, 5'd26:           r = 16'hE052;
      5'd21:                         r = 16'h014B;
      default:                       r = 16'h0000;
    endcase
    return r;
  endfunction

  // {moves, to_initial, residual}
  function automatic logic [10:0] final_lia(input logic [4:0] f);
    logic [10:0] r;
    case (f)
      5'd1:  r = {1'b1, 5'd0,  5'd0};
      5'd2:  r = {1'b1, 5'd1,  5'd0};
      5'd3:  r = {1'b1, 5'd9,  5'd1};
      5'd5:  r = {1'b1, 5'd12, 5'd4};
      5'd7:  r = {1'b1, 5'd3,  5'd0};
      5'd8:  r = {1'b1, 5'd5,  5'd0};
      5'd9:  r = {1'b1, 5'd0,  5'd8};
      5'd10: r = {1'b1, 5'd6,  5'd8};
      5'd11: r = {1'b1, 5'd7,  5'd8};
      5'd12: r = {1'b1, 5'd9,  5'd8};
      5'd13: r = {1'b1, 5'd16, 5'd8};
      5'd14: r = {1'b1, 5'd17, 5'd8};
      5'd17: r = {1'b1, 5'd7,  5'd0};
      5'd18: r = {1'b1, 5'd9,  5'd17};
      5'd19: r = {1'b1, 5'd9,  5'd0};
      5'd20: r = {1'b1, 5'd10, 5'd0};
      5'd22: r = {1'b1, 5'd12, 5'd0};
      5'd23: r = {1'b1, 5'd14, 5'd0};
      5'd24: r = {1'b1, 5'd15, 5'd0};
      5'd25: r = {1'b1, 5'd16, 5'd0};
      5'd26: r = {1'b1, 5'd17, 5'd0};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic is_punct(input logic [20:0] c);
    return c == 21'h2C || c == 21'h2E || c == 21'h3B || c == 21'h3A ||
           c == 21'h21 || c == 21'h3F || c == 21'h3002 || c == 21'hFF0C ||
           c == 21'hFF01 || c == 21'hFF1F || c == 21'h3001;
  endfunction

  function automatic work_t emit_syl(input work_t w);
    work_t r;
    syl_t  s;
    r = w;
    if (w.st.hv) begin
      s = '{v: 1'b1, ini: w.st.hi, med: w.st.hm, fin: w.st.hf};
      if (!r.rec.s1.v && !r.rec.sp && !r.rec.cv) r.rec.s1 = s;
      else r.rec.s2 = s;
      r.st.tn = 1'b1;
      r.st.hv = 1'b0;
    end
    return r;
  endfunction

  function automatic work_t end_run(input work_t w);
    work_t r;
    r = w;
    if (w.st.hv) begin
      r = emit_syl(r);
      r.st.sw = 1'b1;
    end
    return r;
  endfunction

  function automatic work_t pending_to_held(input work_t w);
    work_t r;
    r = w;
    r.st.hi = w.st.pl;
    r.st.hm = w.st.pv;
    r.st.hf = '0;
    r.st.hv = 1'b1;
    r.st.phase = PH_IDLE;
    return r;
  endfunction

  function automatic logic lia_hit(input st_t s, input logic [4:0] init);
    logic [10:0] e;
    e = final_lia(s.hf);
    return s.hv && s.hf != '0 && init == SilentInit && e[10];
  endfunction

  function automatic logic [4:0] join_init(input st_t s, input logic [4:0] init);
    logic [10:0] e;
    e = final_lia(s.hf);
    return lia_hit(s, init) ? e[9:5] : init;
  endfunction

  function automatic work_t join_run(input work_t w, input logic [4:0] init);
    work_t       r;
    logic [10:0] e;
    r = w;
    e = final_lia(w.st.hf);
    if (w.st.hv) begin
      if (lia_hit(w.st, init)) r.st.hf = e[4:0];
      r = emit_syl(r);
    end else if (w.st.sw && w.st.tn) begin
      r.rec.sp = 1'b1;
      r.st.tn = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/hts_front.sv =====
`default_nettype none
module hts_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire hts_pkg::in_item_t in_i,
  input  wire hts_pkg::q_stat_t  q_stat_i,
  output logic                   q_push_o,
  output hts_pkg::rec_t          q_data_o
);
  import hts_pkg::*;

  logic      s1_v_q, s1_v_d;
  cls_item_t s1_q, s1_d;
  st_t       st_q, st_d;
  logic      take, adv;

  logic [20:0] c;
  logic [13:0] code;
  logic [4:0]  ini;

  assign full = s1_v_q && q_stat_i.full;
  assign take = push && !full;
  assign adv  = s1_v_q && !q_stat_i.full;

  // Classify and split the syllable row.
  always_comb begin
    c    = in_i.codepoint;
    code = 14'(c - SylBase);
    ini  = '0;
    for (int k = 1; k < 19; k++) begin
      if (code >= 14'(k * RowLen)) ini = 5'(k);
    end
    s1_d     = '0;
    s1_d.eot = in_i.end_of_text;
    s1_d.cls = CL_OTHER;
    if (c == 21'h20 || c == 21'h09 || c == 21'h0A || c == 21'h0D) begin
      s1_d.cls = CL_WS;
    end else if (is_punct(c)) begin
      s1_d.cls = CL_PUNCT;
      s1_d.ch  = c[15:0];
    end else if (c >= SylBase && c <= SylLast) begin
      s1_d.cls = CL_SYL;
      s1_d.idx = ini;
      s1_d.rem = 10'(code - 14'(ini) * 14'(RowLen));
    end else if ((c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A)) begin
      s1_d.cls = CL_LETTER;
      s1_d.ch  = c[15:0] | 16'h0020;
    end else if (c >= LeadBase && c <= LeadLast) begin
      s1_d.cls = CL_LEAD;
      s1_d.idx = 5'(c - LeadBase);
    end else if (c >= VowelBase && c <= VowelLast) begin
      s1_d.cls = CL_VOWEL;
      s1_d.idx = 5'(c - VowelBase);
    end else if (c >= TrailBase && c <= TrailLast) begin
      s1_d.cls = CL_TRAIL;
      s1_d.idx = 5'(c - TrailBase + 21'd1);
    end
  end

  always_comb begin
    s1_v_d = s1_v_q;
    if (take) s1_v_d = 1'b1;
    else if (adv) s1_v_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_q <= s1_d;
    end
  end

  // Sequence one item against the compose and hold state.
  work_t      w;
  logic [4:0] med, fin, adj, join_in;
  logic       do_plain, join_req, vowel_path;

  always_comb begin
    med = '0;
    for (int k = 1; k < 21; k++) begin
      if (s1_q.rem >= 10'(k * ColLen)) med = 5'(k);
    end
    fin        = 5'(s1_q.rem - 10'(med * 10'(ColLen)));
    w.st       = st_q;
    w.rec      = '0;
    do_plain   = 1'b0;
    join_req   = 1'b0;
    vowel_path = 1'b0;
    join_in    = '0;
    adj        = '0;
    unique case (st_q.phase)
      PH_LEAD: begin
        if (s1_q.cls == CL_VOWEL) begin
          join_req   = 1'b1;
          vowel_path = 1'b1;
          join_in    = st_q.pl;
        end else begin
          w.st.phase = PH_IDLE;
          w          = end_run(w);
          do_plain   = 1'b1;
        end
      end
      PH_VOWEL: begin
        w = pending_to_held(w);
        if (s1_q.cls == CL_TRAIL) w.st.hf = s1_q.idx;
        else do_plain = 1'b1;
      end
      default: begin
        w.st.phase = PH_IDLE;
        do_plain   = 1'b1;
      end
    endcase
    if (do_plain) begin
      unique case (s1_q.cls)
        CL_WS: begin
          w       = end_run(w);
          w.st.sw = 1'b1;
        end
        CL_PUNCT: begin
          w        = end_run(w);
          w.rec.cv = 1'b1;
          w.rec.ch = s1_q.ch;
          w.st.tn  = 1'b1;
          w.st.sw  = 1'b0;
        end
        CL_SYL: begin
          join_req = 1'b1;
          join_in  = s1_q.idx;
        end
        CL_LETTER: begin
          w = end_run(w);
          if (w.st.sw && w.st.tn) w.rec.sp = 1'b1;
          w.rec.cv = 1'b1;
          w.rec.ch = s1_q.ch;
          w.st.tn  = 1'b1;
          w.st.sw  = 1'b1;
        end
        CL_LEAD: begin
          w.st.phase = PH_LEAD;
          w.st.pl    = s1_q.idx;
        end
        default: begin
          w = end_run(w);
        end
      endcase
    end
    if (join_req) begin
      adj = join_init(w.st, join_in);
      w   = join_run(w, join_in);
      if (vowel_path) begin
        w.st.pl    = adj;
        w.st.pv    = s1_q.idx;
        w.st.phase = PH_VOWEL;
      end else begin
        w.st.hi = adj;
        w.st.hm = med;
        w.st.hf = fin;
        w.st.hv = 1'b1;
      end
    end
    if (s1_q.eot) begin
      if (w.st.phase == PH_VOWEL) w = pending_to_held(w);
      w.st.phase = PH_IDLE;
      w          = end_run(w);
      w.rec.endm = 1'b1;
      w.st       = '0;
    end
    st_d     = adv ? w.st : st_q;
    q_data_o = w.rec;
    q_push_o = adv && (w.rec.s1.v || w.rec.sp || w.rec.cv || w.rec.s2.v || w.rec.endm);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/hts_fifo.sv =====
`default_nettype none
module hts_fifo #(
  parameter int Depth = hts_pkg::QDepthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire hts_pkg::rec_t    wdata_i,
  input  wire logic             pop_i,
  output hts_pkg::rec_t         rdata_o,
  output hts_pkg::q_stat_t      stat_o
);
  import hts_pkg::*;

  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  rec_t          mem_q [Depth];
  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign rdata_o      = mem_q[rp_q];
  assign stat_o.full  = cnt_q == CW'(Depth);
  assign stat_o.empty = cnt_q == '0;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (push_i) wp_d = (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
    if (pop_i)  rp_d = (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/hts_back.sv =====
`default_nettype none
module hts_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hts_pkg::rec_t     head_i,
  input  wire hts_pkg::q_stat_t  q_stat_i,
  output logic                   q_pop_o,
  output logic                   empty,
  input  wire logic              pop,
  output hts_pkg::out_item_t     out_o
);
  import hts_pkg::*;

  logic [NumBeats-1:0] done_q, done_d, pres, rem, rest;
  logic                out_v_q, out_v_d, fire;
  out_item_t           out_q, out_d;
  beat_e               sel;

  assign empty = !out_v_q;
  assign out_o = out_q;

  always_comb begin
    pres = '0;
    pres[B_S1_INI]  = head_i.s1.v && initial_ph(head_i.s1.ini) != '0;
    pres[B_S1_MED0] = head_i.s1.v;
    pres[B_S1_MED1] = head_i.s1.v && medial_ph1(head_i.s1.med) != '0;
    pres[B_S1_FIN]  = head_i.s1.v && final_ph(head_i.s1.fin) != '0;
    pres[B_SPACE]   = head_i.sp;
    pres[B_CHAR]    = head_i.cv;
    pres[B_S2_INI]  = head_i.s2.v && initial_ph(head_i.s2.ini) != '0;
    pres[B_S2_MED0] = head_i.s2.v;
    pres[B_S2_MED1] = head_i.s2.v && medial_ph1(head_i.s2.med) != '0;
    pres[B_S2_FIN]  = head_i.s2.v && final_ph(head_i.s2.fin) != '0;
    pres[B_END]     = head_i.endm;
    rem = pres & ~done_q;
    sel = B_END;
    for (int k = NumBeats - 1; k >= 0; k--) begin
      if (rem[k]) sel = beat_e'(k);
    end
    rest = rem & ~(NumBeats'(1) << sel);

    out_d = '0;
    unique case (sel)
      B_S1_INI:  out_d.phoneme = initial_ph(head_i.s1.ini);
      B_S1_MED0: out_d.phoneme = medial_ph0(head_i.s1.med);
      B_S1_MED1: out_d.phoneme = medial_ph1(head_i.s1.med);
      B_S1_FIN:  out_d.phoneme = final_ph(head_i.s1.fin);
      B_SPACE:   out_d.phoneme = SpaceCh;
      B_CHAR:    out_d.phoneme = head_i.ch;
      B_S2_INI:  out_d.phoneme = initial_ph(head_i.s2.ini);
      B_S2_MED0: out_d.phoneme = medial_ph0(head_i.s2.med);
      B_S2_MED1: out_d.phoneme = medial_ph1(head_i.s2.med);
      B_S2_FIN:  out_d.phoneme = final_ph(head_i.s2.fin);
      default:   out_d.end_marker = 1'b1;
    endcase

    fire    = !q_stat_i.empty && (!out_v_q || pop);
    q_pop_o = 1'b0;
    done_d  = done_q;
    out_v_d = out_v_q;
    if (fire) begin
      out_v_d = 1'b1;
      if (rest == '0) begin
        q_pop_o = 1'b1;
        done_d  = '0;
      end else begin
        done_d = done_q | (NumBeats'(1) << sel);
      end
    end else if (pop) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      done_q  <= '0;
    end else begin
      out_v_q <= out_v_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

endmodule
`default_nettype wire

// ===== src/hangul_text_to_phoneme_stream_unit.sv =====
// Path: an accepted codepoint is registered in stage 1, its record (if any) is written to the
// record queue, and the back loads its beats into the output register that drives out_o.
// Throughput: one codepoint per cycle into the front while the record queue has room; one beat
// per cycle out of the back while out_o is empty or popped; the single output port sets the pace.
// Reset (rst_ni low, asynchronous): compose/hold state, queue and output valid flag clear.
`default_nettype none
module hangul_text_to_phoneme_stream_unit #(
  parameter int QDepth = hts_pkg::QDepthDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire hts_pkg::in_item_t  in_i,
  output logic                    empty,
  input  wire logic               pop,
  output hts_pkg::out_item_t      out_o
);
  import hts_pkg::*;

  // Front: classify the codepoint, then run liaison and recomposition
  // against the held syllable; each item leaves at most one record.
  q_stat_t q_stat;
  logic    q_push, q_pop;
  rec_t    q_wdata, q_head;

  hts_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .in_i     (in_i),
    .q_stat_i (q_stat),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  // Short record queue: lets the front keep taking codepoints while the
  // back drains a long syllable.
  hts_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_head),
    .stat_o  (q_stat)
  );

  // Back: expand a record into beats, one per cycle while out_o is empty or
  // popped, through the output register; drop the record once its last beat is loaded.
  hts_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (q_head),
    .q_stat_i (q_stat),
    .q_pop_o  (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_o    (out_o)
  );

endmodule
`default_nettype wire

// ===== src/hts_checker.sv =====
`default_nettype none
module hts_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               push,
  input wire logic               full,
  input wire hts_pkg::in_item_t  in_i,
  input wire logic               empty,
  input wire logic               pop,
  input wire hts_pkg::out_item_t out_o
);
  import hts_pkg::*;

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> empty)
    else $error("result visible right after reset");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_o))
    else $error("stalled beat changed");

  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_o.end_marker |-> out_o.phoneme == '0)
    else $error("end beat carries a phoneme");

  a_ph_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !out_o.end_marker |-> out_o.phoneme != '0)
    else $error("zero phoneme beat");

  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |-> !$isunknown(in_i))
    else $error("accepted beat with unknown payload");

endmodule

bind hangul_text_to_phoneme_stream_unit hts_checker u_hts_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .push   (push),
  .full   (full),
  .in_i   (in_i),
  .empty  (empty),
  .pop    (pop),
  .out_o  (out_o)
);
`default_nettype wire
